@@ design/msc_pkg.sv @@
// Package: shared codes, widths and the result record for the MSI snoop controller.
`default_nettype none
package msc_pkg;

    // Table geometry (block number is taken modulo the table depth)
    localparam int NUM_BLOCKS = 16;
    localparam int NUM_CORES  = 4;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int ADDR_W     = 4;
    localparam int CORE_W     = 2;
    localparam int DATA_W     = 32;

    // Item kinds
    localparam logic [1:0] KIND_CPU_RD = 2'd0;
    localparam logic [1:0] KIND_CPU_WR = 2'd1;
    localparam logic [1:0] KIND_SNOOP  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // Snooped bus message types
    localparam logic [1:0] MSG_RD_REQ  = 2'd0;
    localparam logic [1:0] MSG_WR_REQ  = 2'd1;
    localparam logic [1:0] MSG_RD_DONE = 2'd2;
    localparam logic [1:0] MSG_WR_DONE = 2'd3;

    // Issued bus request types
    localparam logic BUS_RD = 1'b0;
    localparam logic BUS_WR = 1'b1;

    // Block states
    localparam logic [1:0] ST_INVALID  = 2'd0;
    localparam logic [1:0] ST_SHARED   = 2'd1;
    localparam logic [1:0] ST_MODIFIED = 2'd2;

    typedef logic [1:0] t_blk_state;

    // One result beat
    typedef struct packed {
        logic              bus_req_valid;
        logic              bus_req_type;
        logic [ADDR_W-1:0] bus_req_address;
        logic [DATA_W-1:0] bus_req_data;
        logic              cache_read;
        logic              ready_set;
        logic [DATA_W-1:0] data_out;
        logic              fill_valid;
        logic [ADDR_W-1:0] fill_address;
        logic [DATA_W-1:0] fill_data;
    } t_rsp;

endpackage
`default_nettype wire

@@ design/msc_if.sv @@
// Interfaces: request channel and result channel of the MSI snoop controller.
`default_nettype none
interface msc_req_if import msc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] block_address;
    logic [DATA_W-1:0] data_in;
    logic              ready_pending;
    logic [1:0]        msg_type;
    logic [CORE_W-1:0] msg_core;

    modport source (
        output valid, kind, block_address, data_in, ready_pending, msg_type, msg_core,
        input  ready
    );
    modport sink (
        input  valid, kind, block_address, data_in, ready_pending, msg_type, msg_core,
        output ready
    );
endinterface

interface msc_rsp_if import msc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              bus_req_valid;
    logic              bus_req_type;
    logic [ADDR_W-1:0] bus_req_address;
    logic [DATA_W-1:0] bus_req_data;
    logic              cache_read;
    logic              ready_set;
    logic [DATA_W-1:0] data_out;
    logic              fill_valid;
    logic [ADDR_W-1:0] fill_address;
    logic [DATA_W-1:0] fill_data;

    modport source (
        output valid, bus_req_valid, bus_req_type, bus_req_address, bus_req_data,
               cache_read, ready_set, data_out, fill_valid, fill_address, fill_data,
        input  ready
    );
    modport sink (
        input  valid, bus_req_valid, bus_req_type, bus_req_address, bus_req_data,
               cache_read, ready_set, data_out, fill_valid, fill_address, fill_data,
        output ready
    );
endinterface
`default_nettype wire

@@ design/msi_snoop_cache_controller.sv @@
// Top level: MSI snooping coherence controller for one core of a write-through cache.
//
// Usage:
//   i_req  carries one event per beat: a CPU read, a CPU write or a snooped bus
//          message, with its block number, data and the issuing core.
//   o_rsp  returns exactly one result beat per request beat: bus request to issue,
//          cache read strobe, ready to the processor and cache fill.
//   i_cfg_we / i_cfg_wdata load the core id; write it only while the block is idle.
// Timing:
//   A beat is captured in an input register; the block state table is then read
//   and updated and the result is registered in the result register. One beat
//   per cycle is sustained while o_rsp.ready stays high, set by the single
//   read-modify-write of the state table per cycle.
// Reset (synchronous, active low): every block goes Invalid, the waiting flag
//   and core id clear, both pipeline registers empty.
// Stall: when o_rsp.ready is low the result holds; one more beat may sit in the
//   input register, then i_req.ready drops until the result is taken.
`default_nettype none
module msi_snoop_cache_controller import msc_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [CORE_W-1:0]   i_cfg_wdata,
    msc_req_if.sink            i_req,
    msc_rsp_if.source          o_rsp
);

    // Configuration and coherence state
    logic [CORE_W-1:0] r_core_id;
    logic              r_waiting;
    logic              n_waiting;
    t_blk_state        r_state [NUM_BLOCKS];

    // Input register
    logic              r_in_valid;
    logic [1:0]        r_kind;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_data;
    logic              r_rdy_pend;
    logic [1:0]        r_mtype;
    logic [CORE_W-1:0] r_mcore;

    // Result register
    logic r_out_valid;
    t_rsp r_rsp;
    t_rsp n_rsp;

    // Table update for the item in the input register
    logic [IDX_W-1:0] idx;
    t_blk_state       cur_st;
    t_blk_state       n_st;
    logic             st_we;
    logic             own;
    logic             advance;
    logic             in_fire;

    // Handshake: result stage moves when empty or taken, input stage behind it
    assign advance  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_in_valid || advance;
    assign in_fire  = i_req.valid && i_req.ready;

    // Block number modulo the table depth
    assign idx    = r_addr[IDX_W-1:0];
    assign cur_st = r_state[idx];
    assign own    = (r_mcore == r_core_id);

    // Core id register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_id <= '0;
        end else if (i_cfg_we) begin
            r_core_id <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind     <= i_req.kind;
            r_addr     <= i_req.block_address;
            r_data     <= i_req.data_in;
            r_rdy_pend <= i_req.ready_pending;
            r_mtype    <= i_req.msg_type;
            r_mcore    <= i_req.msg_core;
        end
    end

    // Coherence decision for one beat
    always_comb begin
        n_rsp     = '0;
        n_waiting = r_waiting;
        n_st      = cur_st;
        st_we     = 1'b0;
        unique case (r_kind)
            KIND_CPU_RD, KIND_CPU_WR: begin
                if (!r_waiting && !r_rdy_pend) begin
                    if (r_kind == KIND_CPU_RD &&
                        (cur_st == ST_SHARED || cur_st == ST_MODIFIED)) begin
                        // read hit
                        n_rsp.cache_read = 1'b1;
                        n_rsp.ready_set  = 1'b1;
                        n_waiting        = 1'b0;
                    end else begin
                        // read miss or write: go to the bus
                        n_rsp.bus_req_valid   = 1'b1;
                        n_rsp.bus_req_type    = (r_kind == KIND_CPU_WR) ? BUS_WR : BUS_RD;
                        n_rsp.bus_req_address = r_addr;
                        n_rsp.bus_req_data    = r_data;
                        n_waiting             = 1'b1;
                    end
                end
            end
            KIND_SNOOP: begin
                if (cur_st == ST_MODIFIED) begin
                    if (!own) begin
                        st_we = 1'b1;
                        n_st  = (r_mtype == MSG_RD_REQ || r_mtype == MSG_RD_DONE) ?
                                ST_SHARED : ST_INVALID;
                    end else if (r_mtype == MSG_WR_DONE) begin
                        n_rsp.ready_set = 1'b1;
                        n_waiting       = 1'b0;
                    end
                end else if (cur_st == ST_SHARED) begin
                    if (own) begin
                        if (r_mtype == MSG_WR_REQ) begin
                            st_we = 1'b1;
                            n_st  = ST_MODIFIED;
                        end else if (r_mtype == MSG_WR_DONE) begin
                            n_rsp.ready_set = 1'b1;
                            n_waiting       = 1'b0;
                            st_we           = 1'b1;
                            n_st            = ST_MODIFIED;
                        end else if (r_mtype == MSG_RD_DONE) begin
                            n_rsp.ready_set = 1'b1;
                            n_waiting       = 1'b0;
                        end
                    end else if (r_mtype == MSG_WR_REQ || r_mtype == MSG_WR_DONE) begin
                        st_we = 1'b1;
                        n_st  = ST_INVALID;
                    end
                end else begin
                    // Invalid, or the unused code treated as Invalid
                    if (own && (r_mtype == MSG_RD_DONE || r_mtype == MSG_WR_DONE)) begin
                        n_rsp.ready_set = 1'b1;
                        n_waiting       = 1'b0;
                        st_we           = 1'b1;
                        n_st            = (r_mtype == MSG_RD_DONE) ? ST_SHARED : ST_MODIFIED;
                    end
                end
                // completion carries the data back and fills the cache
                if (n_rsp.ready_set) begin
                    n_rsp.data_out     = r_data;
                    n_rsp.fill_valid   = 1'b1;
                    n_rsp.fill_address = r_addr;
                    n_rsp.fill_data    = r_data;
                end
            end
            KIND_NONE: begin
                n_rsp = '0;
            end
            default: begin
                n_rsp = '0;
            end
        endcase
    end

    // State table and waiting flag, updated when the beat moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting <= 1'b0;
            for (int b = 0; b < NUM_BLOCKS; b++) begin
                r_state[b] <= ST_INVALID;
            end
        end else if (r_in_valid && advance) begin
            r_waiting <= n_waiting;
            if (st_we) begin
                r_state[idx] <= n_st;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_rsp <= n_rsp;
        end
    end

    // Result channel
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.bus_req_valid   = r_rsp.bus_req_valid;
    assign o_rsp.bus_req_type    = r_rsp.bus_req_type;
    assign o_rsp.bus_req_address = r_rsp.bus_req_address;
    assign o_rsp.bus_req_data    = r_rsp.bus_req_data;
    assign o_rsp.cache_read      = r_rsp.cache_read;
    assign o_rsp.ready_set       = r_rsp.ready_set;
    assign o_rsp.data_out        = r_rsp.data_out;
    assign o_rsp.fill_valid      = r_rsp.fill_valid;
    assign o_rsp.fill_address    = r_rsp.fill_address;
    assign o_rsp.fill_data       = r_rsp.fill_data;

    // Checks
    a_bus_sets_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && n_rsp.bus_req_valid) |=> r_waiting)
        else $error("bus request issued without entering the waiting state");

    a_bus_excludes_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_rsp.bus_req_valid && r_rsp.ready_set))
        else $error("bus request and ready in the same beat");

    a_fill_is_completion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rsp.fill_valid) |->
            (r_rsp.ready_set && !r_rsp.cache_read && r_rsp.fill_data == r_rsp.data_out))
        else $error("cache fill not matched by a completion");

    a_hit_needs_valid_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && n_rsp.cache_read) |->
            (cur_st == ST_SHARED || cur_st == ST_MODIFIED))
        else $error("read hit on an invalid block");

endmodule
`default_nettype wire
